FILE: rtl/core/i2cebm_pkg.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte master package
// Request and result types, codes and reset values shared by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cebm_pkg;

  // Default width of the half-period tick counter
  localparam int unsigned TICK_COUNT_WIDTH_DEF = 16;

  // Configuration register widths and reset values
  localparam int unsigned HALF_PERIOD_W = 16;
  localparam int unsigned ACK_TIMEOUT_W = 8;
  localparam int unsigned DEV_ADDR_W    = 7;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned CFG_INDEX_W   = 2;

  localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RST = 16'd8;
  localparam logic [ACK_TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 8'd255;
  localparam logic [DEV_ADDR_W-1:0]    DEV_ADDR_RST    = 7'd80;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DEV_ADDR    = 2'd2;

  // Request kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Completion status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DEV_NACK  = 2'd1;
  localparam logic [1:0] ST_WORD_NACK = 2'd2;
  localparam logic [1:0] ST_DATA_NACK = 2'd3;

  // Byte stage within a transaction
  localparam logic [1:0] STG_DEV   = 2'd0;
  localparam logic [1:0] STG_WORD  = 2'd1;
  localparam logic [1:0] STG_DATA  = 2'd2;
  localparam logic [1:0] STG_RDDEV = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] mem_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
  } res_t;

endpackage : i2cebm_pkg

`default_nettype wire

FILE: rtl/core/i2c_eeprom_byte_master_core.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte master core
// A request's result is registered, in the result register or, behind a held result, in the skid register.
// Throughput: one request per cycle while the input is not stalled; each request advances the bus by one tick.
// A two-entry output stage (result register plus skid register) sets the stall:
// the input stalls only while the skid register holds a result.
// Reset: bus released, idle, status ok, read byte zero, registers at defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_eeprom_byte_master_core #(
  parameter int unsigned TICK_COUNT_WIDTH = i2cebm_pkg::TICK_COUNT_WIDTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // request channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire i2cebm_pkg::req_t                   in_req_i,
  // result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output i2cebm_pkg::res_t                        out_res_o,
  // configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [i2cebm_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [i2cebm_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  import i2cebm_pkg::*;

  // Bus sequencer phases
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_ST_A    = 4'd1;
  localparam logic [3:0] PH_ST_B    = 4'd2;
  localparam logic [3:0] PH_TX_LO   = 4'd3;
  localparam logic [3:0] PH_TX_HI   = 4'd4;
  localparam logic [3:0] PH_AK_LO   = 4'd5;
  localparam logic [3:0] PH_AK_HI   = 4'd6;
  localparam logic [3:0] PH_AK_POLL = 4'd7;
  localparam logic [3:0] PH_RS_LO   = 4'd8;
  localparam logic [3:0] PH_RX_LO   = 4'd9;
  localparam logic [3:0] PH_RX_HI   = 4'd10;
  localparam logic [3:0] PH_NK_LO   = 4'd11;
  localparam logic [3:0] PH_NK_HI   = 4'd12;
  localparam logic [3:0] PH_SP_LO   = 4'd13;
  localparam logic [3:0] PH_SP_SET  = 4'd14;
  localparam logic [3:0] PH_SP_END  = 4'd15;

  // Compare width covers both the configured half period and the counter
  localparam int unsigned CmpW = (TICK_COUNT_WIDTH > HALF_PERIOD_W) ?
                                 TICK_COUNT_WIDTH : HALF_PERIOD_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [HALF_PERIOD_W-1:0] half_period_q;
  logic [ACK_TIMEOUT_W-1:0] ack_timeout_q;
  logic [DEV_ADDR_W-1:0]    dev_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RST;
      ack_timeout_q <= ACK_TIMEOUT_RST;
      dev_addr_q    <= DEV_ADDR_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HALF_PERIOD: half_period_q <= cfg_wdata_i[HALF_PERIOD_W-1:0];
        CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_wdata_i[ACK_TIMEOUT_W-1:0];
        CFG_DEV_ADDR:    dev_addr_q    <= cfg_wdata_i[DEV_ADDR_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: result register backed by a skid register
  // --------------------------------------------------------------------------
  logic out_vld_q, skid_vld_q;
  res_t out_res_q, skid_res_q;
  res_t res_new;
  logic in_acc, out_take;

  assign in_stall_o  = skid_vld_q;
  assign in_acc      = in_valid_i && !skid_vld_q;
  assign out_take    = out_vld_q && !out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_take) begin
      // Refill from the skid register first, then from a fresh request
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= in_acc;
      end
    end else if (in_acc) begin
      if (out_vld_q) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      if (skid_vld_q) begin
        out_res_q <= skid_res_q;
      end else if (in_acc) begin
        out_res_q <= res_new;
      end
    end else if (in_acc) begin
      if (out_vld_q) begin
        skid_res_q <= res_new;
      end else begin
        out_res_q <= res_new;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  logic [3:0]                  phase_q, phase_d;
  logic [TICK_COUNT_WIDTH-1:0] tick_q, tick_d;
  logic [3:0]                  bit_idx_q, bit_idx_d;
  logic [7:0]                  shift_q, shift_d;
  logic [7:0]                  polls_q, polls_d;
  logic [7:0]                  held_addr_q, held_addr_d;
  logic [7:0]                  held_data_q, held_data_d;
  logic                        is_read_q, is_read_d;
  logic [1:0]                  last_status_q, last_status_d;
  logic [1:0]                  stage_q, stage_d;
  logic [1:0]                  pend_status_q, pend_status_d;
  logic [7:0]                  rx_byte_q, rx_byte_d;

  // Half-period limit: clip to the counter range, never below one tick
  logic [CmpW-1:0] hp_ext, cap_ext, half_lim, tick_inc;
  logic [7:0]      poll_lim;

  always_comb begin
    hp_ext   = CmpW'(half_period_q);
    cap_ext  = CmpW'({TICK_COUNT_WIDTH{1'b1}});
    half_lim = (hp_ext > cap_ext) ? cap_ext : hp_ext;
    if (half_lim == '0) begin
      half_lim = CmpW'(1);
    end
    poll_lim = (ack_timeout_q == '0) ? 8'd1 : ack_timeout_q;
  end

  // One bus tick per request
  logic scl_drv, sda_drv, done;

  always_comb begin
    phase_d       = phase_q;
    tick_d        = tick_q;
    bit_idx_d     = bit_idx_q;
    shift_d       = shift_q;
    polls_d       = polls_q;
    held_addr_d   = held_addr_q;
    held_data_d   = held_data_q;
    is_read_d     = is_read_q;
    last_status_d = last_status_q;
    stage_d       = stage_q;
    pend_status_d = pend_status_q;
    rx_byte_d     = rx_byte_q;
    scl_drv       = 1'b1;
    sda_drv       = 1'b1;
    done          = 1'b0;
    tick_inc      = '0;

    // Take a new transaction only while idle; the first START tick follows at once
    if (phase_q == PH_IDLE && (in_req_i.kind == KIND_WRITE || in_req_i.kind == KIND_READ)) begin
      held_addr_d   = in_req_i.mem_addr;
      held_data_d   = in_req_i.write_data;
      is_read_d     = (in_req_i.kind == KIND_READ);
      stage_d       = STG_DEV;
      pend_status_d = ST_OK;
      bit_idx_d     = '0;
      polls_d       = '0;
      phase_d       = PH_ST_A;
      tick_d        = '0;
    end

    if (phase_d == PH_IDLE) begin
      scl_drv = 1'b1;
      sda_drv = 1'b1;
    end else if (phase_d == PH_AK_POLL) begin
      // SCL held high, SDA released: wait for the target to pull SDA low
      if (!in_req_i.sda_in) begin
        tick_d = '0;
        case (stage_d)
          STG_DEV: begin
            stage_d   = STG_WORD;
            shift_d   = held_addr_d;
            bit_idx_d = '0;
            phase_d   = PH_TX_LO;
          end
          STG_WORD: begin
            if (is_read_d) begin
              stage_d = STG_RDDEV;
              phase_d = PH_RS_LO;
            end else begin
              stage_d   = STG_DATA;
              shift_d   = held_data_d;
              bit_idx_d = '0;
              phase_d   = PH_TX_LO;
            end
          end
          STG_DATA: begin
            pend_status_d = ST_OK;
            phase_d       = PH_SP_LO;
          end
          default: begin
            // address ACK of the read: start receiving
            shift_d   = '0;
            bit_idx_d = '0;
            phase_d   = PH_RX_LO;
          end
        endcase
      end else begin
        polls_d = polls_q + 8'd1;
        if (polls_d >= poll_lim || polls_d == '0) begin
          case (stage_d)
            STG_DEV:  pend_status_d = ST_DEV_NACK;
            STG_WORD: pend_status_d = ST_WORD_NACK;
            default:  pend_status_d = ST_DATA_NACK;
          endcase
          phase_d = PH_SP_LO;
          tick_d  = '0;
        end
      end
    end else begin
      case (phase_d)
        PH_ST_A:   begin scl_drv = 1'b1; sda_drv = 1'b1;       end
        PH_ST_B:   begin scl_drv = 1'b1; sda_drv = 1'b0;       end
        PH_TX_LO:  begin scl_drv = 1'b0; sda_drv = shift_d[7]; end
        PH_TX_HI:  begin scl_drv = 1'b1; sda_drv = shift_d[7]; end
        PH_AK_LO:  begin scl_drv = 1'b0; sda_drv = 1'b1;       end
        PH_AK_HI:  begin scl_drv = 1'b1; sda_drv = 1'b1;       end
        PH_RS_LO:  begin scl_drv = 1'b0; sda_drv = 1'b1;       end
        PH_RX_LO:  begin scl_drv = 1'b0; sda_drv = 1'b1;       end
        PH_RX_HI: begin
          scl_drv = 1'b1;
          sda_drv = 1'b1;
          // sample each read bit on the first tick of SCL high
          if (tick_d == '0) begin
            shift_d = {shift_d[6:0], in_req_i.sda_in};
          end
        end
        PH_NK_LO:  begin scl_drv = 1'b0; sda_drv = 1'b1;       end
        PH_NK_HI:  begin scl_drv = 1'b1; sda_drv = 1'b1;       end
        PH_SP_LO:  begin scl_drv = 1'b0; sda_drv = 1'b0;       end
        PH_SP_SET: begin scl_drv = 1'b1; sda_drv = 1'b0;       end
        default:   begin scl_drv = 1'b1; sda_drv = 1'b1;       end
      endcase

      tick_inc = CmpW'(tick_d) + CmpW'(1);
      tick_d   = tick_inc[TICK_COUNT_WIDTH-1:0];

      if (tick_inc >= half_lim) begin
        // half period over: advance the sequencer
        tick_d = '0;
        case (phase_d)
          PH_ST_A: phase_d = PH_ST_B;
          PH_ST_B: begin
            shift_d   = {dev_addr_q, (stage_d == STG_RDDEV)};
            bit_idx_d = '0;
            phase_d   = PH_TX_LO;
          end
          PH_TX_LO: phase_d = PH_TX_HI;
          PH_TX_HI: begin
            shift_d   = {shift_d[6:0], 1'b0};
            bit_idx_d = bit_idx_d + 4'd1;
            phase_d   = (bit_idx_d >= 4'd8) ? PH_AK_LO : PH_TX_LO;
          end
          PH_AK_LO: phase_d = PH_AK_HI;
          PH_AK_HI: begin
            polls_d = '0;
            phase_d = PH_AK_POLL;
          end
          PH_RS_LO: phase_d = PH_ST_A;
          PH_RX_LO: phase_d = PH_RX_HI;
          PH_RX_HI: begin
            bit_idx_d = bit_idx_d + 4'd1;
            if (bit_idx_d >= 4'd8) begin
              rx_byte_d = shift_d;
              phase_d   = PH_NK_LO;
            end else begin
              phase_d = PH_RX_LO;
            end
          end
          PH_NK_LO:  phase_d = PH_NK_HI;
          PH_NK_HI:  phase_d = PH_SP_LO;
          PH_SP_LO:  phase_d = PH_SP_SET;
          PH_SP_SET: phase_d = PH_SP_END;
          default: begin
            // end of STOP: publish the status and go idle
            last_status_d = pend_status_d;
            phase_d       = PH_IDLE;
            done          = 1'b1;
          end
        endcase
      end
    end

    res_new.scl_level   = scl_drv;
    res_new.sda_release = sda_drv;
    res_new.busy_res    = (phase_d != PH_IDLE);
    res_new.done_res    = done;
    res_new.status      = last_status_d;
    res_new.read_data   = rx_byte_d;
  end

  // Advance the sequencer only on a taken request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      tick_q        <= '0;
      bit_idx_q     <= '0;
      shift_q       <= '0;
      polls_q       <= '0;
      held_addr_q   <= '0;
      held_data_q   <= '0;
      is_read_q     <= 1'b0;
      last_status_q <= ST_OK;
      stage_q       <= STG_DEV;
      pend_status_q <= ST_OK;
      rx_byte_q     <= '0;
    end else if (in_acc) begin
      phase_q       <= phase_d;
      tick_q        <= tick_d;
      bit_idx_q     <= bit_idx_d;
      shift_q       <= shift_d;
      polls_q       <= polls_d;
      held_addr_q   <= held_addr_d;
      held_data_q   <= held_data_d;
      is_read_q     <= is_read_d;
      last_status_q <= last_status_d;
      stage_q       <= stage_d;
      pend_status_q <= pend_status_d;
      rx_byte_q     <= rx_byte_d;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The skid register only fills behind a held result
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register full while result register empty");

  // A finishing tick always leaves the master idle
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_res_q.done_res) |-> !out_res_q.busy_res)
    else $error("done reported while still busy");

  // The tick counter is cleared whenever the sequencer rests
  a_idle_tick_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (tick_q == '0))
    else $error("tick counter not cleared in idle");

  // The bus is released on every plain tick request taken while idle
  a_idle_released : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PH_IDLE && in_req_i.kind == KIND_TICK) |=>
      (out_res_q.scl_level && out_res_q.sda_release && !out_res_q.busy_res))
    else $error("bus driven while idle");

endmodule : i2c_eeprom_byte_master_core

`default_nettype wire

FILE: test/i2c_eeprom_byte_master_core_test.sv
// ----------------------------------------------------------------------------
// I2C EEPROM byte master core testbench
// Drives bus ticks through the request channel, plays the EEPROM slave on
// SDA, and checks every bus result against a cycle-true software copy of the
// master. Register settings change between runs of traffic.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_master_core_test;
  import i2cebm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  // Kind three has no meaning and must behave as a plain tick
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Bus phases of the master, one per timed half period or poll
  typedef enum logic [4:0] {
    PH_IDLE, PH_START_HI, PH_START_LO, PH_BIT_LO, PH_BIT_HI, PH_ACK_LO,
    PH_ACK_HI, PH_ACK_POLL, PH_RESTART_LO, PH_RX_LO, PH_RX_HI, PH_NACK_LO,
    PH_NACK_HI, PH_STOP_LO, PH_STOP_SETUP, PH_STOP_END
  } bus_phase_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  req_t                   in_req = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  res_t                   out_res;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_HALF_PERIOD;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Register copies as the master sees them
  logic [HALF_PERIOD_W-1:0] cfg_half    = HALF_PERIOD_RST;
  logic [ACK_TIMEOUT_W-1:0] cfg_timeout = ACK_TIMEOUT_RST;
  logic [DEV_ADDR_W-1:0]    cfg_dev     = DEV_ADDR_RST;

  // Master state, mirrored tick by tick
  bus_phase_e  m_phase  = PH_IDLE;
  int unsigned m_ticks  = 0;
  logic [3:0]  m_bit    = '0;
  logic [7:0]  m_shift  = '0;
  logic [7:0]  m_polls  = '0;
  logic [7:0]  m_addr   = '0;
  logic [7:0]  m_data   = '0;
  logic        m_read   = 1'b0;
  logic [1:0]  m_status = ST_OK;
  logic        m_scl    = 1'b1;
  logic        m_sda    = 1'b1;
  logic [1:0]  m_stage  = STG_DEV;
  logic [1:0]  m_pend   = ST_OK;
  logic [7:0]  m_rx     = '0;

  res_t        bus_outlook[$];
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          valid_raised = 1'b0;

  // Slave behaviour and idling knobs
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned ack_pct = 100;
  bit          refuse_on = 1'b0;
  logic [1:0]  refuse_stage = STG_DEV;

  i2c_eeprom_byte_master_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver stall, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Bus master mirror
  // ---------------------------------------------------------------------------

  function automatic void enter_phase(input bus_phase_e p);
    m_phase = p;
    m_ticks = 0;
  endfunction

  function automatic void start_byte(input logic [7:0] b);
    m_shift = b;
    m_bit   = '0;
    enter_phase(PH_BIT_LO);
  endfunction

  // Advance the master by one tick and return the line levels and status.
  function automatic res_t eeprom_bus_tick(input req_t r);
    res_t        o;
    bit          done;
    int unsigned lim;
    done = 1'b0;
    // A request is only taken while the bus is idle
    if (m_phase == PH_IDLE && (r.kind == KIND_WRITE || r.kind == KIND_READ)) begin
      m_addr  = r.mem_addr;
      m_data  = r.write_data;
      m_read  = (r.kind == KIND_READ);
      m_stage = STG_DEV;
      m_pend  = ST_OK;
      m_bit   = '0;
      m_polls = '0;
      enter_phase(PH_START_HI);
    end
    if (m_phase == PH_IDLE) begin
      m_scl = 1'b1;
      m_sda = 1'b1;
    end else if (m_phase == PH_ACK_POLL) begin
      m_scl = 1'b1;
      m_sda = 1'b1;
      if (!r.sda_in) begin
        // Acknowledged: move on to the next byte of the transaction
        case (m_stage)
          STG_DEV: begin
            m_stage = STG_WORD;
            start_byte(m_addr);
          end
          STG_WORD: begin
            if (m_read) begin
              m_stage = STG_RDDEV;
              enter_phase(PH_RESTART_LO);
            end else begin
              m_stage = STG_DATA;
              start_byte(m_data);
            end
          end
          STG_DATA: begin
            m_pend = ST_OK;
            enter_phase(PH_STOP_LO);
          end
          default: begin
            m_shift = '0;
            m_bit   = '0;
            enter_phase(PH_RX_LO);
          end
        endcase
      end else begin
        lim = (cfg_timeout == 0) ? 1 : cfg_timeout;
        m_polls = m_polls + 8'd1;
        if (m_polls >= lim || m_polls == 0) begin
          case (m_stage)
            STG_DEV:  m_pend = ST_DEV_NACK;
            STG_WORD: m_pend = ST_WORD_NACK;
            default:  m_pend = ST_DATA_NACK;
          endcase
          enter_phase(PH_STOP_LO);
        end
      end
    end else begin
      case (m_phase)
        PH_START_HI:   begin m_scl = 1'b1; m_sda = 1'b1; end
        PH_START_LO:   begin m_scl = 1'b1; m_sda = 1'b0; end
        PH_BIT_LO:     begin m_scl = 1'b0; m_sda = m_shift[7]; end
        PH_BIT_HI:     begin m_scl = 1'b1; m_sda = m_shift[7]; end
        PH_ACK_LO,
        PH_RESTART_LO,
        PH_RX_LO,
        PH_NACK_LO:    begin m_scl = 1'b0; m_sda = 1'b1; end
        PH_RX_HI: begin
          m_scl = 1'b1;
          m_sda = 1'b1;
          // Sample the data bit on the first tick of SCL high
          if (m_ticks == 0) m_shift = {m_shift[6:0], r.sda_in};
        end
        PH_STOP_LO:    begin m_scl = 1'b0; m_sda = 1'b0; end
        PH_STOP_SETUP: begin m_scl = 1'b1; m_sda = 1'b0; end
        default:       begin m_scl = 1'b1; m_sda = 1'b1; end
      endcase
      m_ticks++;
      if (m_ticks >= ((cfg_half == 0) ? 1 : cfg_half)) begin
        case (m_phase)
          PH_START_HI:   enter_phase(PH_START_LO);
          PH_START_LO:   start_byte({cfg_dev, m_stage == STG_RDDEV});
          PH_BIT_LO:     enter_phase(PH_BIT_HI);
          PH_BIT_HI: begin
            m_shift = {m_shift[6:0], 1'b0};
            m_bit   = m_bit + 4'd1;
            enter_phase((m_bit >= 8) ? PH_ACK_LO : PH_BIT_LO);
          end
          PH_ACK_LO:     enter_phase(PH_ACK_HI);
          PH_ACK_HI: begin
            m_polls = '0;
            enter_phase(PH_ACK_POLL);
          end
          PH_RESTART_LO: enter_phase(PH_START_HI);
          PH_RX_LO:      enter_phase(PH_RX_HI);
          PH_RX_HI: begin
            m_bit = m_bit + 4'd1;
            if (m_bit >= 8) begin
              m_rx = m_shift;
              enter_phase(PH_NACK_LO);
            end else begin
              enter_phase(PH_RX_LO);
            end
          end
          PH_NACK_LO:    enter_phase(PH_NACK_HI);
          PH_NACK_HI:    enter_phase(PH_STOP_LO);
          PH_STOP_LO:    enter_phase(PH_STOP_SETUP);
          PH_STOP_SETUP: enter_phase(PH_STOP_END);
          default: begin
            m_status = m_pend;
            enter_phase(PH_IDLE);
            done = 1'b1;
          end
        endcase
      end
    end
    o.scl_level   = m_scl;
    o.sda_release = m_sda;
    o.busy_res    = (m_phase != PH_IDLE);
    o.done_res    = done;
    o.status      = m_status;
    o.read_data   = m_rx;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
    end
  endtask

  always @(posedge clk) begin : watch_results
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (bus_outlook.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing pending: %p", results_seen, out_res);
      end else begin
        want = bus_outlook.pop_front();
        check_field("scl_level",   want.scl_level,   out_res.scl_level);
        check_field("sda_release", want.sda_release, out_res.sda_release);
        check_field("busy_res",    want.busy_res,    out_res.busy_res);
        check_field("done_res",    want.done_res,    out_res.done_res);
        check_field("status",      want.status,      out_res.status);
        check_field("read_data",   want.read_data,   out_res.read_data);
      end
      results_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driving
  // ---------------------------------------------------------------------------

  // Drop valid once; a shadow flag keeps to one assignment per time step.
  task automatic hold_sender();
    if (valid_raised) begin
      in_valid     <= 1'b0;
      valid_raised = 1'b0;
    end
  endtask

  // Send one tick request; the slave's SDA level follows the bus phase.
  task automatic drive_tick(input logic [1:0] kind, input logic [7:0] addr,
                            input logic [7:0] data);
    req_t r;
    r.kind       = kind;
    r.mem_addr   = addr;
    r.write_data = data;
    if (m_phase == PH_ACK_POLL)
      r.sda_in = (refuse_on && m_stage == refuse_stage) ? 1'b1
                                                         : ($urandom_range(0, 99) >= ack_pct);
    else
      r.sda_in = 1'($urandom_range(0, 1));
    in_req       <= r;
    in_valid     <= 1'b1;
    valid_raised = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bus_outlook.push_back(eeprom_bus_tick(r));
    items_sent++;
    // Random sender gap after the request
    while ($urandom_range(0, 99) < send_idle_pct) begin
      hold_sender();
      @(posedge clk);
    end
  endtask

  // Mostly plain ticks while busy, with the odd stray request that must be ignored
  function automatic logic [1:0] stray_kind();
    return ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3)) : KIND_TICK;
  endfunction

  task automatic finish_transfer();
    while (m_phase != PH_IDLE)
      drive_tick(stray_kind(), 8'($urandom), 8'($urandom));
  endtask

  task automatic run_transfer(input logic [1:0] kind, input logic [7:0] addr,
                              input logic [7:0] data);
    drive_tick(kind, addr, data);
    finish_transfer();
  endtask

  task automatic wait_for_drain();
    hold_sender();
    @(posedge clk);
    while (bus_outlook.size() != 0) @(posedge clk);
  endtask

  // Write all three registers back to back once nothing is in flight.
  task automatic program_registers(input logic [15:0] half, input logic [7:0] timeout,
                                   input logic [6:0] dev);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HALF_PERIOD;
    cfg_wdata <= half;
    @(posedge clk);
    cfg_index <= CFG_ACK_TIMEOUT;
    cfg_wdata <= CFG_DATA_W'(timeout);
    @(posedge clk);
    cfg_index <= CFG_DEV_ADDR;
    cfg_wdata <= CFG_DATA_W'(dev);
    @(posedge clk);
    cfg_we      <= 1'b0;
    cfg_half    = half;
    cfg_timeout = timeout;
    cfg_dev     = dev;
  endtask

  // Pause until every result is back, then pick new random settings
  task automatic redraw_registers();
    program_registers(($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 12))
                                                  : 16'($urandom_range(1, 3)),
                      ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) :
                      ($urandom_range(0, 2) == 0) ? 8'd255
                                                  : 8'($urandom_range(4, 40)),
                      7'($urandom_range(0, 127)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle bus at reset settings: plain and spare kinds must leave the lines high.
  task automatic test_idle_ticks();
    drive_tick(KIND_TICK, 8'h00, 8'h00);
    drive_tick(KIND_SPARE, 8'hFF, 8'hFF);
    drive_tick(KIND_TICK, 8'hFF, 8'h00);
    drive_tick(KIND_SPARE, 8'h00, 8'hFF);
  endtask

  // Byte writes at the fastest rate, zero half period standing for one tick.
  task automatic test_byte_write();
    program_registers(16'd0, ACK_TIMEOUT_RST, 7'h7F);
    ack_pct   = 100;
    refuse_on = 1'b0;
    run_transfer(KIND_WRITE, 8'hFF, 8'h00);
    run_transfer(KIND_WRITE, 8'h00, 8'hFF);
  endtask

  // Random reads with the slave returning random bits; receiver stalls too.
  task automatic test_random_read();
    program_registers(16'd2, ACK_TIMEOUT_RST, 7'h00);
    recv_stall_pct = 58;
    run_transfer(KIND_READ, 8'hA5, 8'h5A);
    run_transfer(KIND_READ, 8'hFF, 8'h00);
    recv_stall_pct = 0;
  endtask

  // Refuse each byte in turn; a failed read must keep the last byte read.
  task automatic test_missing_ack();
    program_registers(16'd1, 8'd0, DEV_ADDR_RST);
    refuse_on    = 1'b1;
    refuse_stage = STG_DEV;
    run_transfer(KIND_WRITE, 8'h12, 8'h34);
    refuse_stage = STG_WORD;
    run_transfer(KIND_WRITE, 8'h56, 8'h78);
    refuse_stage = STG_DATA;
    run_transfer(KIND_WRITE, 8'h9A, 8'hBC);
    refuse_stage = STG_RDDEV;
    run_transfer(KIND_READ, 8'hDE, 8'hF0);
    // Full-length timeout on the device address
    program_registers(16'd1, 8'd255, DEV_ADDR_RST);
    refuse_stage = STG_DEV;
    run_transfer(KIND_READ, 8'h01, 8'h02);
    refuse_on = 1'b0;
  endtask

  // Slave holds off its ACK for a while but answers within the timeout.
  task automatic test_slow_ack();
    program_registers(16'd1, 8'd255, 7'h2A);
    ack_pct = 4;
    run_transfer(KIND_WRITE, 8'h33, 8'hCC);
    run_transfer(KIND_READ, 8'hCC, 8'h33);
    ack_pct = 100;
  endtask

  // Longest half period, then shorten it mid-transaction.
  task automatic test_register_while_busy();
    program_registers(16'hFFFF, 8'd40, DEV_ADDR_RST);
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    drive_tick(KIND_READ, 8'h3C, 8'hC3);
    repeat (150) drive_tick(stray_kind(), 8'($urandom), 8'($urandom));
    program_registers(16'd1, 8'd40, DEV_ADDR_RST);
    finish_transfer();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Random transactions through each idling pattern, with settings redrawn
  // at the start and halfway through every pattern.
  task automatic test_random_traffic();
    int unsigned pattern;
    int unsigned half_at;
    int unsigned stop_at;
    bit          resettled;
    logic [1:0]  kind;
    for (pattern = 0; pattern < 4; pattern++) begin
      case (pattern)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      half_at   = items_sent + 75;
      stop_at   = items_sent + 150;
      redraw_registers();
      resettled = 1'b0;
      while (items_sent < stop_at) begin
        if (!resettled && items_sent >= half_at) begin
          redraw_registers();
          resettled = 1'b1;
        end
        refuse_on    = ($urandom_range(0, 7) == 0);
        refuse_stage = 2'($urandom_range(0, 3));
        ack_pct      = $urandom_range(40, 100);
        // Mostly well-formed transactions, some idle noise
        kind = ($urandom_range(0, 9) < 8) ? (($urandom_range(0, 1) != 0) ? KIND_WRITE : KIND_READ)
                                          : 2'($urandom_range(0, 3));
        run_transfer(kind, 8'($urandom), 8'($urandom));
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_ticks();
    test_byte_write();
    test_random_read();
    test_missing_ack();
    test_slow_ack();
    test_register_while_busy();
    test_random_traffic();
    // Drain, then keep clocking so that any stray result shows
    wait_for_drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && bus_outlook.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/i2cebm_pkg.sv
rtl/core/i2c_eeprom_byte_master_core.sv
test/i2c_eeprom_byte_master_core_test.sv
